FILE: sv/sha1_message_digest_core_defines.svh
// Assertion macros used by the checker of the SHA-1 digest core.
`ifndef SHA1_MESSAGE_DIGEST_CORE_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_CORE_DEFINES_SVH

// Check cons in the same cycle as ante.
`define SHA1MD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sha1md: check failed");

// Check cons in the cycle after ante.
`define SHA1MD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sha1md: check failed");

`endif

FILE: sv/sha1md_pkg.sv
package sha1md_pkg;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_UPDATE,
    ST_PAD,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    P_MARK,
    P_ZERO,
    P_LEN
  } pad_phase_e;

  localparam int ChainWords = 5;
  localparam int BlockWords = 16;

  localparam word_t ChainInit [ChainWords] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [6:0] RoundLast    = 7'd79;
  localparam logic [2:0] WordLast     = 3'd4;
  localparam logic [5:0] FillLenStart = 6'd56;
  localparam logic [5:0] FillLast     = 6'd63;
  localparam logic [7:0] PadMark      = 8'h80;

  function automatic word_t sha1md_f(logic [6:0] rnd, word_t b, word_t c, word_t d);
    word_t f;
    priority if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic word_t sha1md_k(logic [6:0] rnd);
    word_t k;
    priority if (rnd < 7'd20) begin
      k = 32'h5A827999;
    end else if (rnd < 7'd40) begin
      k = 32'h6ED9EBA1;
    end else if (rnd < 7'd60) begin
      k = 32'h8F1BBCDC;
    end else begin
      k = 32'hCA62C1D6;
    end
    return k;
  endfunction

endpackage

FILE: sv/sha1_message_digest_core.sv
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+-------------------------------------
// in       | sink      | in_valid_i / in_stall_o | data_byte_i, byte_valid_i, is_last_i
// out      | source    | out_valid_o / out_stall_i | digest_word_o, word_index_o, last_word_o
//
// A byte item is accepted while idle; the item that fills a 64-byte block adds a compression:
// 80 rounds through the single shared round adder, then a chain update state.
// A last item adds the padding bytes (up to 72), one per cycle, and one or two compressions,
// then the five digest words, one per cycle that out_stall_i stays low.
// Reset loads the initial chain and clears counters; no clearing pass is needed.
// in_stall_o is low only while idle; the digest words hold while out_stall_i is high.
module sha1_message_digest_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import sha1md_pkg::*;

  // Control state
  state_e      state_q, state_d;
  pad_phase_e  phase_q, phase_d;
  logic [5:0]  fill_q, fill_d;
  logic [60:0] total_q, total_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [2:0]  idx_q, idx_d;
  logic        last_q, last_d;
  logic        len_done_q, len_done_d;

  // Chain and datapath
  word_t chain_q [ChainWords];
  word_t chain_d [ChainWords];
  word_t win_q [BlockWords];
  word_t win_d [BlockWords];
  logic [23:0] acc_q;
  word_t a_q, b_q, c_q, d_q, e_q;

  logic        in_acc, out_acc;
  logic        put_en, wrap;
  logic [7:0]  put_val;
  logic [5:0]  fill_inc;
  logic [63:0] len_bits;
  word_t       sched_x, sched_new, round_t;

  assign in_acc   = in_valid_i & ~in_stall_o;
  assign out_acc  = out_valid_o & ~out_stall_i;
  assign fill_inc = fill_q + 6'd1;
  assign len_bits = {total_q, 3'b000};
  assign wrap     = put_en && (fill_q == FillLast);

  // Pick the byte written into the block this cycle.
  always_comb begin
    put_en  = 1'b0;
    put_val = '0;
    unique case (state_q)
      ST_IDLE: begin
        put_en  = in_acc & byte_valid_i;
        put_val = data_byte_i;
      end
      ST_PAD: begin
        put_en = 1'b1;
        unique case (phase_q)
          P_MARK:  put_val = PadMark;
          P_ZERO:  put_val = '0;
          P_LEN:   put_val = len_bits[{~fill_q[2:0], 3'b000} +: 8];
          default: put_val = '0;
        endcase
      end
      default: begin
        put_en  = 1'b0;
        put_val = '0;
      end
    endcase
  end

  // Sequencer: next state and counters.
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    fill_d     = put_en ? fill_inc : fill_q;
    total_d    = total_q;
    rnd_d      = rnd_q;
    idx_d      = idx_q;
    last_d     = last_q;
    len_done_d = len_done_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_acc) begin
          if (byte_valid_i) begin
            total_d = total_q + 61'd1;
          end
          last_d     = is_last_i;
          phase_d    = P_MARK;
          len_done_d = 1'b0;
          if (wrap) begin
            state_d = ST_ROUND;
            rnd_d   = '0;
          end else if (is_last_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == RoundLast) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        idx_d = '0;
        priority if (!last_q) begin
          state_d = ST_IDLE;
        end else if (len_done_q) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_PAD;
        end
      end
      ST_PAD: begin
        // Advance through mark, zero fill and length bytes.
        if ((phase_q != P_LEN) && (fill_inc == FillLenStart)) begin
          phase_d = P_LEN;
        end else if (phase_q == P_MARK) begin
          phase_d = P_ZERO;
        end
        if (wrap) begin
          state_d    = ST_ROUND;
          rnd_d      = '0;
          len_done_d = (phase_q == P_LEN);
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (idx_q == WordLast) begin
            state_d = ST_IDLE;
            total_d = '0;
            fill_d  = '0;
            last_d  = 1'b0;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      phase_q    <= P_MARK;
      fill_q     <= '0;
      total_q    <= '0;
      rnd_q      <= '0;
      idx_q      <= '0;
      last_q     <= 1'b0;
      len_done_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      fill_q     <= fill_d;
      total_q    <= total_d;
      rnd_q      <= rnd_d;
      idx_q      <= idx_d;
      last_q     <= last_d;
      len_done_q <= len_done_d;
    end
  end

  // Shared round unit and message schedule on a 16-word window.
  assign sched_x   = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
  assign sched_new = {sched_x[30:0], sched_x[31]};
  assign round_t   = {a_q[26:0], a_q[31:27]} + sha1md_f(rnd_q, b_q, c_q, d_q)
                   + e_q + sha1md_k(rnd_q) + win_q[0];

  always_comb begin
    for (int i = 0; i < BlockWords; i++) begin
      win_d[i] = win_q[i];
    end
    if (put_en && (fill_q[1:0] == 2'd3)) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[BlockWords-1] = {acc_q, put_val};
    end else if (state_q == ST_ROUND) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[BlockWords-1] = sched_new;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < BlockWords; i++) begin
      win_q[i] <= win_d[i];
    end
    if (put_en) begin
      acc_q <= {acc_q[15:0], put_val};
    end
    if (wrap) begin
      // Load the working variables as the block completes.
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
      e_q <= chain_q[4];
    end else if (state_q == ST_ROUND) begin
      a_q <= round_t;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
  end

  // Chain: add the working variables after each block; reload after the last word.
  always_comb begin
    for (int i = 0; i < ChainWords; i++) begin
      chain_d[i] = chain_q[i];
    end
    if (state_q == ST_UPDATE) begin
      chain_d[0] = chain_q[0] + a_q;
      chain_d[1] = chain_q[1] + b_q;
      chain_d[2] = chain_q[2] + c_q;
      chain_d[3] = chain_q[3] + d_q;
      chain_d[4] = chain_q[4] + e_q;
    end else if (out_acc && (idx_q == WordLast)) begin
      for (int i = 0; i < ChainWords; i++) begin
        chain_d[i] = ChainInit[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ChainWords; i++) begin
        chain_q[i] <= ChainInit[i];
      end
    end else begin
      for (int i = 0; i < ChainWords; i++) begin
        chain_q[i] <= chain_d[i];
      end
    end
  end

  assign digest_word_o = chain_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == WordLast);

endmodule

FILE: sv/sha1md_checker.sv
`include "sha1_message_digest_core_defines.svh"

module sha1md_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  word_index_o,
  input logic        last_word_o
);
  import sha1md_pkg::*;

  // No item is taken while digest words go out.
  `SHA1MD_ASSERT_SAME(a_no_in_while_out, clk_i, rst_ni, out_valid_o, in_stall_o)

  `SHA1MD_ASSERT_SAME(a_last_is_word4, clk_i, rst_ni, out_valid_o,
                      last_word_o == (word_index_o == WordLast))

  // Words follow each other with no gap and a rising index.
  `SHA1MD_ASSERT_NEXT(a_index_steps, clk_i, rst_ni, out_valid_o && !out_stall_i && !last_word_o,
                      out_valid_o && (word_index_o == 3'($past(word_index_o) + 3'd1)))

  `SHA1MD_ASSERT_NEXT(a_hold_on_stall, clk_i, rst_ni, out_valid_o && out_stall_i,
                      out_valid_o && $stable(digest_word_o) && $stable(word_index_o))

endmodule

bind sha1_message_digest_core sha1md_checker u_sha1md_checker (.*);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sha1md_pkg::*;

  localparam int RandomItems = 400;
  localparam int MinMessages = 12;
  localparam int DrainCycles = 300;
  localparam int MaxReports  = 10;

  // Predicts the digest words of each message and checks them in order.
  class digest_scoreboard;
    typedef struct packed {
      word_t      word;
      logic [2:0] index;
      logic       tail;
    } digest_t;

    digest_t     expected_words[$];
    word_t       chain[ChainWords];
    word_t       block[BlockWords];
    logic [60:0] byte_count;
    logic [5:0]  fill;
    int          faults;

    function new();
      faults = 0;
      restart();
    endfunction

    function void restart();
      foreach (chain[i]) chain[i] = ChainInit[i];
      foreach (block[i]) block[i] = '0;
      byte_count = '0;
      fill = '0;
    endfunction

    function word_t rotl(word_t x, int unsigned n);
      return (x << n) | (x >> (32 - n));
    endfunction

    // Pack one byte big-endian; run the 80 rounds once the block is full.
    function void absorb(logic [7:0] val);
      word_t sched[16];
      word_t a, b, c, d, e, f, k, t, w;
      word_t shifted;
      logic [3:0] slot;
      logic [1:0] lane;
      slot = fill[5:2];
      lane = fill[1:0];
      shifted = {24'b0, val} << (24 - 8 * lane);
      if (lane == 2'd0) begin
        block[slot] = shifted;
      end else begin
        block[slot] = block[slot] | shifted;
      end
      fill = fill + 6'd1;
      if (fill != 6'd0) return;
      sched = block;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int r = 0; r < 80; r++) begin
        if (r < 16) begin
          w = sched[r];
        end else begin
          w = rotl(sched[(r + 13) % 16] ^ sched[(r + 8) % 16] ^
                   sched[(r + 2) % 16] ^ sched[r % 16], 1);
          sched[r % 16] = w;
        end
        if (r < 20) begin
          f = (b & c) | (~b & d);
          k = 32'h5A827999;
        end else if (r < 40) begin
          f = b ^ c ^ d;
          k = 32'h6ED9EBA1;
        end else if (r < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = 32'h8F1BBCDC;
        end else begin
          f = b ^ c ^ d;
          k = 32'hCA62C1D6;
        end
        t = rotl(a, 5) + f + e + k + w;
        e = d;
        d = c;
        c = rotl(b, 30);
        b = a;
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    // Take one accepted input item; on the last one pad and queue h0..h4.
    function void note_item(logic [7:0] data, logic valid, logic last);
      logic [63:0] bit_len;
      digest_t entry;
      if (valid) begin
        absorb(data);
        byte_count = byte_count + 61'd1;
      end
      if (!last) return;
      bit_len = {byte_count, 3'b000};
      absorb(PadMark);
      while (fill != FillLenStart) absorb(8'h00);
      for (int i = 7; i >= 0; i--) absorb(bit_len[8 * i +: 8]);
      for (int i = 0; i < ChainWords; i++) begin
        entry.word  = chain[i];
        entry.index = 3'(i);
        entry.tail  = (i == ChainWords - 1);
        expected_words = {expected_words, entry};
      end
      restart();
    endfunction

    function void check_word(word_t word, logic [2:0] index, logic tail);
      digest_t want;
      if (expected_words.size() == 0) begin
        faults++;
        if (faults <= MaxReports)
          $display("unexpected digest word %h index %0d last %b", word, index, tail);
        return;
      end
      want = expected_words.pop_front();
      if (word !== want.word || index !== want.index || tail !== want.tail) begin
        faults++;
        if (faults <= MaxReports)
          $display("digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                   want.word, want.index, want.tail, word, index, tail);
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic [7:0]  data_byte_i  = 8'h00;
  logic        byte_valid_i = 1'b0;
  logic        is_last_i    = 1'b0;
  logic        out_stall_i  = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  digest_scoreboard scoreboard;
  bit calm = 1'b0;
  int items_sent = 0;
  int messages_sent = 0;

  sha1_message_digest_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .byte_valid_i  (byte_valid_i),
    .is_last_i     (is_last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o)
  );

  always #10 clk_i = ~clk_i;

  // Check digest words on accept; stall the output at random.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      scoreboard.check_word(digest_word_o, word_index_o, last_word_o);
    out_stall_i <= rst_ni && !calm && ($urandom_range(0, 99) < 9);
  end

  // Offer one item, with an optional idle cycle first, and hold it until taken.
  task automatic drive_item(input logic [7:0] data, input logic valid, input logic last);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 9) gap = 1;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= data;
    byte_valid_i <= valid;
    is_last_i    <= last;
    do @(posedge clk_i); while (in_stall_o);
    scoreboard.note_item(data, valid, last);
    items_sent++;
  endtask

  // Stream one message; end it either on its final byte or on an empty last item.
  task automatic send_message(input int len);
    bit carry_last;
    carry_last = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 5) drive_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      drive_item(8'($urandom_range(0, 255)), 1'b1, carry_last && (i == len - 1));
    end
    if (!carry_last) drive_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    messages_sent++;
  endtask

  initial begin
    int len;
    int pick;
    int edge_lens[9];
    edge_lens = '{54, 55, 56, 57, 63, 64, 65, 119, 120};
    scoreboard = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty item right after reset, then the empty message twice.
    drive_item(8'hFF, 1'b0, 1'b0);
    drive_item(8'h00, 1'b0, 1'b1);
    drive_item(8'hFF, 1'b0, 1'b1);
    // One-byte messages carried on the last item, both byte extremes.
    drive_item(8'h00, 1'b1, 1'b1);
    drive_item(8'hFF, 1'b1, 1'b1);
    // "abc" with an empty item inside, closed by an empty last item.
    drive_item(8'h61, 1'b1, 1'b0);
    drive_item(8'h00, 1'b0, 1'b0);
    drive_item(8'h62, 1'b1, 1'b0);
    drive_item(8'h63, 1'b1, 1'b0);
    drive_item(8'hFF, 1'b0, 1'b1);
    // Extreme bytes inside a message.
    drive_item(8'hFF, 1'b1, 1'b0);
    drive_item(8'h00, 1'b1, 1'b0);
    drive_item(8'h80, 1'b1, 1'b1);

    items_sent = 0;
    messages_sent = 0;
    while (items_sent < RandomItems || messages_sent < MinMessages) begin
      calm = (messages_sent >= 6 && messages_sent < 10);
      if (messages_sent == 4) begin
        // Hold off the input until every digest word has drained.
        in_valid_i <= 1'b0;
        while (scoreboard.pending() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        len = $urandom_range(0, 12);
      end else if (pick < 85) begin
        len = edge_lens[$urandom_range(0, 8)];
      end else begin
        len = $urandom_range(13, 140);
      end
      send_message(len);
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (scoreboard.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (scoreboard.faults == 0 && scoreboard.pending() == 0) begin
      $display("sha1_message_digest_core test passed");
    end else begin
      $display("sha1_message_digest_core test failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("sha1_message_digest_core test failed");
    $finish;
  end

endmodule
